### design/first_fit_page_allocator_unit_macros.svh
// Assertion helpers for the page allocator
`ifndef FIRST_FIT_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// checked outside reset
`define FFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define FFPA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ffpa_pkg.sv
package ffpa_pkg;

  localparam int START_W = 13;
  localparam int SIZE_W  = 14;
  localparam int STAT_W  = 2;
  localparam int FREE_W  = 6;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 14'h3FFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TRIM,
    OP_DEL,
    OP_MERGE_BOTH,
    OP_MERGE_LO,
    OP_MERGE_HI,
    OP_INSERT
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_POST
  } state_t;

  typedef struct packed {
    op_t               op;
    logic              cmd;
    logic [START_W-1:0] base;
    logic [SIZE_W-1:0]  count;
  } ffpa_ctl_t;

  typedef struct packed {
    logic               stop;
    logic               hit;
    logic               empty;
    logic               lo;
    logic               hi;
    logic [START_W-1:0] start;
  } ffpa_rep_t;

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SIZE_LIMIT}) ? SIZE_LIMIT : s[SIZE_W-1:0];
  endfunction

endpackage

### design/ffpa_cell.sv
module ffpa_cell import ffpa_pkg::*; #(
  parameter int MAX_EXTENTS = 32,
  parameter int IDX = 0,
  parameter logic [SIZE_W-1:0] RESET_SIZE = 14'h2000,
  localparam int IW = $clog2(MAX_EXTENTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  ffpa_ctl_t          ctl,
  input  logic [IW-1:0]      pos,
  input  logic [IW-1:0]      used,
  input  logic               tok_in,
  input  logic               lo_in,
  output logic               tok_out,
  output logic               lo_out,
  input  logic [START_W-1:0] left_start,
  input  logic [SIZE_W-1:0]  left_size,
  input  logic [START_W-1:0] right_start,
  input  logic [SIZE_W-1:0]  right_size,
  output logic [START_W-1:0] ext_start,
  output logic [SIZE_W-1:0]  ext_size,
  output ffpa_rep_t          rep
);

  localparam logic [IW-1:0] MY   = IW'(IDX);
  localparam logic [IW-1:0] NEXT = IW'(IDX + 1);

  logic               tok;
  logic               occ;
  logic               fits;
  logic               stop;
  logic [START_W+1:0] ext_end;
  logic [START_W+1:0] req_end;
  logic               ld;
  logic [START_W-1:0] ext_start_next;
  logic [SIZE_W-1:0]  ext_size_next;
  logic               me;
  logic               next_me;
  logic               above;
  logic               at_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  always_comb begin
    occ     = MY < used;
    fits    = ext_size >= ctl.count;
    ext_end = {2'b00, ext_start} + {1'b0, ext_size};
    req_end = {2'b00, ctl.base} + {1'b0, ctl.count};
    if (ctl.cmd == CMD_ALLOC) begin
      stop = tok && (!occ || fits);
    end else begin
      stop = tok && (!occ || (ext_start > ctl.base));
    end
    tok_out = tok && !stop;
    lo_out  = occ && (ext_end == {2'b00, ctl.base});
    rep     = '0;
    if (stop) begin
      rep.stop  = 1'b1;
      rep.hit   = occ && fits;
      rep.empty = ext_size == ctl.count;
      rep.lo    = lo_in;
      rep.hi    = occ && ({2'b00, ext_start} == req_end);
      rep.start = ext_start;
    end
  end

  always_comb begin
    me             = pos == MY;
    next_me        = pos == NEXT;
    above          = MY > pos;
    at_above       = MY >= pos;
    ld             = 1'b0;
    ext_start_next = ext_start;
    ext_size_next  = ext_size;
    case (ctl.op)
      OP_TRIM: begin
        if (me) begin
          ld             = 1'b1;
          ext_start_next = ext_start + ctl.count[START_W-1:0];
          ext_size_next  = ext_size - ctl.count;
        end
      end
      OP_DEL: begin
        if (at_above) begin
          ld             = 1'b1;
          ext_start_next = right_start;
          ext_size_next  = right_size;
        end
      end
      OP_MERGE_BOTH: begin
        if (next_me) begin
          ld            = 1'b1;
          ext_size_next = sat_add(sat_add(ext_size, ctl.count), right_size);
        end else if (at_above) begin
          ld             = 1'b1;
          ext_start_next = right_start;
          ext_size_next  = right_size;
        end
      end
      OP_MERGE_LO: begin
        if (next_me) begin
          ld            = 1'b1;
          ext_size_next = sat_add(ext_size, ctl.count);
        end
      end
      OP_MERGE_HI: begin
        if (me) begin
          ld             = 1'b1;
          ext_start_next = ctl.base;
          ext_size_next  = sat_add(ext_size, ctl.count);
        end
      end
      OP_INSERT: begin
        if (me) begin
          ld             = 1'b1;
          ext_start_next = ctl.base;
          ext_size_next  = ctl.count;
        end else if (above) begin
          ld             = 1'b1;
          ext_start_next = left_start;
          ext_size_next  = left_size;
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst && (IDX == 0)) begin
      ext_start <= '0;
      ext_size  <= RESET_SIZE;
    end else if (ld) begin
      ext_start <= ext_start_next;
      ext_size  <= ext_size_next;
    end
  end

endmodule

### design/ffpa_ctrl.sv
`include "first_fit_page_allocator_unit_macros.svh"

module ffpa_ctrl import ffpa_pkg::*; #(
  parameter int MAX_EXTENTS = 32,
  localparam int IW = $clog2(MAX_EXTENTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [START_W-1:0] base,
  input  logic [SIZE_W-1:0]  count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [START_W-1:0] start_page,
  output logic [FREE_W-1:0]  free_extents,
  output ffpa_ctl_t          ctl,
  output logic [IW-1:0]      pos,
  output logic [IW-1:0]      used,
  output logic               launch,
  input  ffpa_rep_t          rep,
  input  logic               end_tok,
  input  logic               end_lo
);

  state_t             state;
  state_t             state_next;
  logic               req_cmd;
  logic [START_W-1:0] req_base;
  logic [SIZE_W-1:0]  req_count;
  logic [IW-1:0]      scan_idx;
  op_t                op_q;
  logic [STAT_W-1:0]  res_status;
  logic [START_W-1:0] res_start;
  logic               scan_done;
  logic               out_load;
  op_t                dec_op;
  logic [STAT_W-1:0]  dec_status;
  logic [START_W-1:0] dec_start;
  logic               lo;
  logic               hi;

  assign scan_done = rep.stop || end_tok;
  assign out_load  = (state == S_POST) && (!out_valid || !out_stall);

  always_comb begin
    lo         = rep.stop ? rep.lo : end_lo;
    hi         = rep.stop && rep.hi;
    dec_op     = OP_NONE;
    dec_status = ST_NOFIT;
    dec_start  = '0;
    if (req_count != '0) begin
      if (req_cmd == CMD_ALLOC) begin
        if (rep.stop && rep.hit) begin
          dec_op     = rep.empty ? OP_DEL : OP_TRIM;
          dec_status = ST_OK;
          dec_start  = rep.start;
        end
      end else if (lo && hi) begin
        dec_op     = OP_MERGE_BOTH;
        dec_status = ST_OK;
      end else if (lo) begin
        dec_op     = OP_MERGE_LO;
        dec_status = ST_OK;
      end else if (hi) begin
        dec_op     = OP_MERGE_HI;
        dec_status = ST_OK;
      end else if (used >= IW'(MAX_EXTENTS)) begin
        dec_status = ST_FULL;
      end else begin
        dec_op     = OP_INSERT;
        dec_status = ST_OK;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_APPLY;
      S_APPLY: state_next = S_POST;
      S_POST:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != S_IDLE;
    launch    = (state == S_IDLE) && in_valid;
    ctl.op    = (state == S_APPLY) ? op_q : OP_NONE;
    ctl.cmd   = req_cmd;
    ctl.base  = req_base;
    ctl.count = req_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= IW'(1);
      op_q      <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN && scan_done) begin
        op_q <= dec_op;
      end
      if (state == S_APPLY) begin
        case (op_q)
          OP_DEL, OP_MERGE_BOTH: used <= used - 1'b1;
          OP_INSERT:             used <= used + 1'b1;
          default:               used <= used;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      req_cmd   <= cmd;
      req_base  <= base;
      req_count <= count;
      scan_idx  <= '0;
    end else if (state == S_SCAN && !scan_done) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (state == S_SCAN && scan_done) begin
      pos        <= rep.stop ? scan_idx : IW'(MAX_EXTENTS);
      res_status <= dec_status;
      res_start  <= dec_start;
    end
    if (out_load) begin
      status       <= res_status;
      start_page   <= res_start;
      free_extents <= FREE_W'(used);
    end
  end

  `FFPA_ASSERT_RST(a_reset_state, rst |=> used == IW'(1) && state == S_IDLE && !out_valid, "bad reset")
  `FFPA_ASSERT(a_used_max, used <= IW'(MAX_EXTENTS), "extent count over table size")
  `FFPA_ASSERT(a_insert_grows, state == S_APPLY && op_q == OP_INSERT |=> used == $past(used) + 1'b1, "insert did not grow table")
  `FFPA_ASSERT(a_scan_walk, state == S_SCAN && !scan_done |=> state == S_SCAN && scan_idx == $past(scan_idx) + 1'b1, "scan lost token")

endmodule

### design/first_fit_page_allocator_unit.sv
// Order: the word is registered, then the token steps one cell per cycle along the chain
//   to the extent p where the walk stops (at most MAX_EXTENTS - 1), then S_APPLY, S_POST.
// A new word waits until the last result is registered; it is taken while that result waits.
// Reset: synchronous, active high; table holds one extent of min(POOL_PAGES, 16383) at page 0.
module first_fit_page_allocator_unit import ffpa_pkg::*; #(
  parameter int POOL_PAGES  = 8192,
  parameter int MAX_EXTENTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [START_W-1:0] base,
  input  logic [SIZE_W-1:0]  count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [START_W-1:0] start_page,
  output logic [FREE_W-1:0]  free_extents
);

  localparam int IW = $clog2(MAX_EXTENTS + 1);
  localparam logic [SIZE_W-1:0] RESET_SIZE =
    (POOL_PAGES > 16383) ? SIZE_LIMIT : SIZE_W'(POOL_PAGES);

  ffpa_ctl_t          ctl;
  logic [IW-1:0]      pos;
  logic [IW-1:0]      used;
  logic               launch;
  ffpa_rep_t          rep_or;
  ffpa_rep_t          rep_w   [MAX_EXTENTS];
  logic [START_W-1:0] start_w [MAX_EXTENTS];
  logic [SIZE_W-1:0]  size_w  [MAX_EXTENTS];
  logic               tok_c   [MAX_EXTENTS+1];
  logic               lo_c    [MAX_EXTENTS+1];

  assign tok_c[0] = launch;
  assign lo_c[0]  = 1'b0;

  always_comb begin
    rep_or = '0;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      rep_or = ffpa_rep_t'(rep_or | rep_w[i]);
    end
  end

  for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
    logic [START_W-1:0] l_start;
    logic [SIZE_W-1:0]  l_size;
    logic [START_W-1:0] r_start;
    logic [SIZE_W-1:0]  r_size;

    if (g == 0) begin : g_head
      assign l_start = '0;
      assign l_size  = '0;
    end else begin : g_mid
      assign l_start = start_w[g-1];
      assign l_size  = size_w[g-1];
    end

    if (g == MAX_EXTENTS - 1) begin : g_tail
      assign r_start = '0;
      assign r_size  = '0;
    end else begin : g_body
      assign r_start = start_w[g+1];
      assign r_size  = size_w[g+1];
    end

    ffpa_cell #(
      .MAX_EXTENTS(MAX_EXTENTS),
      .IDX        (g),
      .RESET_SIZE (RESET_SIZE)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .pos        (pos),
      .used       (used),
      .tok_in     (tok_c[g]),
      .lo_in      (lo_c[g]),
      .tok_out    (tok_c[g+1]),
      .lo_out     (lo_c[g+1]),
      .left_start (l_start),
      .left_size  (l_size),
      .right_start(r_start),
      .right_size (r_size),
      .ext_start  (start_w[g]),
      .ext_size   (size_w[g]),
      .rep        (rep_w[g])
    );
  end

  ffpa_ctrl #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .base        (base),
    .count       (count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .start_page  (start_page),
    .free_extents(free_extents),
    .ctl         (ctl),
    .pos         (pos),
    .used        (used),
    .launch      (launch),
    .rep         (rep_or),
    .end_tok     (tok_c[MAX_EXTENTS]),
    .end_lo      (lo_c[MAX_EXTENTS])
  );

endmodule

### bench/page_alloc_checker.sv
`timescale 1ns / 1ps
module page_alloc_checker import ffpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               cmd,
  input  logic [START_W-1:0] base,
  input  logic [SIZE_W-1:0]  count,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [STAT_W-1:0]  status,
  input  logic [START_W-1:0] start_page,
  input  logic [FREE_W-1:0]  free_extents,
  output int                 fail_count,
  output int                 pending
);
  localparam int NEXT = 32;
  localparam int POOL = 8192;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] start_page;
    logic [FREE_W-1:0]  free_extents;
  } alloc_result_t;

  logic [START_W-1:0] ext_start [NEXT];
  logic [SIZE_W-1:0]  ext_size [NEXT];
  int                 ext_used;
  alloc_result_t      expected_q [$];

  function automatic logic [SIZE_W-1:0] clamp_add(int a, int b);
    return (a + b > int'(SIZE_LIMIT)) ? SIZE_LIMIT : SIZE_W'(a + b);
  endfunction

  function automatic alloc_result_t predict_page_op(logic c, int b, int n);
    alloc_result_t r;
    int pos, e;
    bit lo, hi;
    r = '0;
    r.status = ST_NOFIT;
    if (n == 0) begin
    end else if (c == CMD_ALLOC) begin
      for (int i = 0; i < ext_used; i++) begin
        if (int'(ext_size[i]) >= n) begin
          r.status = ST_OK;
          r.start_page = ext_start[i];
          ext_start[i] = START_W'(int'(ext_start[i]) + n);
          ext_size[i] = ext_size[i] - SIZE_W'(n);
          if (ext_size[i] == 0) begin
            for (int k = i; k + 1 < ext_used; k++) begin
              ext_start[k] = ext_start[k+1];
              ext_size[k] = ext_size[k+1];
            end
            ext_used--;
          end
          break;
        end
      end
    end else begin
      pos = 0;
      e = b + n;
      while (pos < ext_used && int'(ext_start[pos]) <= b) pos++;
      lo = pos > 0 && int'(ext_start[pos-1]) + int'(ext_size[pos-1]) == b;
      hi = pos < ext_used && int'(ext_start[pos]) == e;
      r.status = ST_OK;
      if (lo && hi) begin
        ext_size[pos-1] = clamp_add(clamp_add(ext_size[pos-1], n), ext_size[pos]);
        for (int k = pos; k + 1 < ext_used; k++) begin
          ext_start[k] = ext_start[k+1];
          ext_size[k] = ext_size[k+1];
        end
        ext_used--;
      end else if (lo) begin
        ext_size[pos-1] = clamp_add(ext_size[pos-1], n);
      end else if (hi) begin
        ext_start[pos] = START_W'(b);
        ext_size[pos] = clamp_add(ext_size[pos], n);
      end else if (ext_used >= NEXT) begin
        r.status = ST_FULL;
      end else begin
        for (int k = ext_used; k > pos; k--) begin
          ext_start[k] = ext_start[k-1];
          ext_size[k] = ext_size[k-1];
        end
        ext_start[pos] = START_W'(b);
        ext_size[pos] = clamp_add(n, 0);
        ext_used++;
      end
    end
    r.free_extents = FREE_W'(ext_used);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      ext_start[0] = '0;
      ext_size[0] = clamp_add(POOL, 0);
      ext_used = 1;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_page_op(cmd, int'(base), int'(count)));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word");
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, status);
            errs++;
          end
          if (start_page !== want.start_page) begin
            $error("start_page: expected %0d actual %0d", want.start_page, start_page);
            errs++;
          end
          if (free_extents !== want.free_extents) begin
            $error("free_extents: expected %0d actual %0d", want.free_extents,
                   free_extents);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ffpa_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic               cmd = CMD_ALLOC;
  logic [START_W-1:0] base = '0;
  logic [SIZE_W-1:0]  count = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [STAT_W-1:0]  status;
  logic [START_W-1:0] start_page;
  logic [FREE_W-1:0]  free_extents;
  int                 fail_count;
  int                 pending;
  bit                 calm = 0;
  bit                 hold_sink = 0;

  // live ranges handed out, used to build plausible frees
  int held_base [$];
  int held_len [$];
  int sent_total = 0;

  always #2 clk = ~clk;

  first_fit_page_allocator_unit DUT (.*);

  page_alloc_checker checker_inst (.*);

  // keep a record of granted ranges
  logic last_cmd_q [$];
  int   last_cnt_q [$];
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      last_cmd_q.push_back(cmd);
      last_cnt_q.push_back(int'(count));
    end
    if (!rst && out_valid && !out_stall) begin
      if (last_cmd_q[0] == CMD_ALLOC && status == ST_OK) begin
        held_base.push_back(int'(start_page));
        held_len.push_back(last_cnt_q[0]);
      end
      void'(last_cmd_q.pop_front());
      void'(last_cnt_q.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst || hold_sink) out_stall <= hold_sink;
    else out_stall <= !calm && ($urandom_range(99) < 6);
  end

  task automatic send_word(logic c, int b, int n);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    base <= START_W'(b);
    count <= SIZE_W'(n);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
  endtask

  task automatic send_random;
    int pick, idx, piece;
    pick = $urandom_range(99);
    if (pick < 45) begin
      piece = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(1, 300);
      send_word(CMD_ALLOC, $urandom, piece);
    end else if (pick < 85 && held_base.size() > 0) begin
      // free all or part of a held range, sometimes out of order
      idx = $urandom_range(held_base.size() - 1);
      piece = $urandom_range(1, held_len[idx]);
      if ($urandom_range(1)) begin
        send_word(CMD_FREE, held_base[idx], piece);
        held_base[idx] += piece;
        held_len[idx] -= piece;
      end else begin
        send_word(CMD_FREE, held_base[idx] + held_len[idx] - piece, piece);
        held_len[idx] -= piece;
      end
      if (held_len[idx] == 0) begin
        held_base.delete(idx);
        held_len.delete(idx);
      end
    end else begin
      send_word($urandom_range(1), $urandom_range(8191),
                ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(40));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_word(CMD_ALLOC, 8191, 0);
    send_word(CMD_FREE, 100, 0);
    send_word(CMD_ALLOC, 0, 16383);
    send_word(CMD_ALLOC, 0, 1);
    send_word(CMD_ALLOC, 0, 8190);
    send_word(CMD_ALLOC, 0, 1);
    send_word(CMD_ALLOC, 0, 1);
    send_word(CMD_FREE, 8191, 1);
    send_word(CMD_FREE, 10, 5);
    send_word(CMD_FREE, 0, 10);
    send_word(CMD_FREE, 20, 4);
    send_word(CMD_FREE, 15, 5);
    send_word(CMD_FREE, 4000, 16383);
    send_word(CMD_FREE, 5000, 16383);
    send_word(CMD_ALLOC, 0, 16383);
    for (int i = 0; i < 34; i++) send_word(CMD_FREE, 6000 + 3 * i, 1);
    send_word(CMD_FREE, 8191, 8191);
    send_word(CMD_ALLOC, 0, 16383);
    // quiet stretch
    calm = 1;
    for (int i = 0; i < 100; i++) send_random();
    calm = 0;
    // long receiver hold while words keep being offered
    fork
      begin
        hold_sink = 1;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 30; i++) send_random();
    join
    for (int i = 0; i < 720; i++) send_random();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/ffpa_pkg.sv
design/ffpa_cell.sv
design/ffpa_ctrl.sv
design/first_fit_page_allocator_unit.sv
bench/page_alloc_checker.sv
bench/testbench.sv
